>>> sv/spq_pkg.sv
// Package: shared types, codes and defaults for the sorted priority queue.
package spq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int KEY_W = 16;
  localparam int PRI_W = 8;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_POP    = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_MATCH,
    CELL_SCAN,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [KEY_W-1:0] key;
    logic [PRI_W-1:0] pri;
    logic             shift_all;
  } cell_ctl_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PRI_W-1:0] pri;
    logic             ge;
    logic             seen;
  } cell_link_t;

endpackage

>>> sv/spq_cell.sv
// One slot of the queue: holds a key and priority, talks to its two neighbors.
module spq_cell #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT,
  parameter int IDX   = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  spq_pkg::cell_ctl_t            ctl,
  input  logic [$clog2(DEPTH+1)-1:0]    occ,
  input  spq_pkg::cell_link_t           left_in,
  input  spq_pkg::cell_link_t           right_in,
  output spq_pkg::cell_link_t           link_out
);

  localparam int OCC_W = $clog2(DEPTH+1);

  logic [spq_pkg::KEY_W-1:0] key;
  logic [spq_pkg::PRI_W-1:0] pri;
  logic                      seen;
  logic                      slot_valid;
  logic                      ge;

  assign slot_valid = occ > OCC_W'(IDX);
  assign ge = slot_valid && (pri >= ctl.pri);

  assign link_out.key  = key;
  assign link_out.pri  = pri;
  assign link_out.ge   = ge;
  assign link_out.seen = seen;

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      spq_pkg::CELL_INSERT: begin
        if (!ge) begin
          if (left_in.ge) begin
            key <= ctl.key;
            pri <= ctl.pri;
          end else begin
            key <= left_in.key;
            pri <= left_in.pri;
          end
        end
      end
      spq_pkg::CELL_SHIFT: begin
        if (seen || ctl.shift_all) begin
          key <= right_in.key;
          pri <= right_in.pri;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else begin
      unique case (ctl.op)
        spq_pkg::CELL_MATCH: seen <= slot_valid && (key == ctl.key);
        spq_pkg::CELL_SCAN:  seen <= seen | left_in.seen;
        default:             seen <= seen;
      endcase
    end
  end

endmodule

>>> sv/sorted_priority_queue_keyed_remove.sv
// Top level: sorted priority queue with remove by key, built as a chain of slot cells.
// A request is taken when start is high and busy is low; its result appears on
// status, removed_key and fallback for exactly one cycle with done high, in the
// cycle after the request for push, pop and clear, so these run one per cycle.
// Remove by key on an empty queue answers like push, pop and clear; otherwise busy is
// high while the match flag ripples one cell per cycle down the chain, before the
// matching slot (the head, with fallback high, if no key matches) is closed up.
// The receiver cannot stall: a result not taken in its cycle is gone.
module sorted_priority_queue_keyed_remove #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                command,
  input  logic [spq_pkg::KEY_W-1:0] key,
  input  logic [spq_pkg::PRI_W-1:0] priority_req,
  output logic                      done,
  output logic [1:0]                status,
  output logic [spq_pkg::KEY_W-1:0] removed_key,
  output logic                      fallback
);

  localparam int OCC_W = $clog2(DEPTH+1);
  localparam int CNT_W = $clog2(DEPTH);

  spq_pkg::state_t           state, state_next;
  logic [CNT_W-1:0]          cnt, cnt_next;
  logic [OCC_W-1:0]          occ, occ_next;
  logic [spq_pkg::KEY_W-1:0] key_hold, key_hold_next;
  logic                      done_next;
  logic [1:0]                status_next;
  logic [spq_pkg::KEY_W-1:0] removed_key_next;
  logic                      fallback_next;
  spq_pkg::cell_ctl_t        ctl;
  spq_pkg::cell_link_t       links [DEPTH];
  logic                      accept;
  logic                      empty;
  logic                      full;
  logic                      found;
  logic                      scan_last;

  assign busy      = (state != spq_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign empty     = (occ == '0);
  assign full      = (occ == OCC_W'(DEPTH));
  assign found     = links[DEPTH-1].seen;
  assign scan_last = (cnt == CNT_W'(DEPTH-1));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::cell_link_t left_in;
    spq_pkg::cell_link_t right_in;
    if (i == 0) begin : g_head
      assign left_in = '{key: '0, pri: '0, ge: 1'b1, seen: 1'b0};
    end else begin : g_mid
      assign left_in = links[i-1];
    end
    if (i == DEPTH-1) begin : g_tail
      assign right_in = '0;
    end else begin : g_body
      assign right_in = links[i+1];
    end
    spq_cell #(.DEPTH(DEPTH), .IDX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .occ      (occ),
      .left_in  (left_in),
      .right_in (right_in),
      .link_out (links[i])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      spq_pkg::ST_IDLE: begin
        if (accept && (command == spq_pkg::CMD_REMOVE) && !empty) begin
          state_next = spq_pkg::ST_SCAN;
        end
      end
      spq_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_next = spq_pkg::ST_IDLE;
        end
      end
      default: state_next = spq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl              = '{op: spq_pkg::CELL_HOLD, key: key, pri: priority_req, shift_all: 1'b0};
    cnt_next         = cnt;
    occ_next         = occ;
    key_hold_next    = key_hold;
    done_next        = 1'b0;
    status_next      = spq_pkg::STATUS_DONE;
    removed_key_next = '0;
    fallback_next    = 1'b0;
    unique case (state)
      spq_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (command)
            spq_pkg::CMD_PUSH: begin
              done_next = 1'b1;
              if (full) begin
                status_next = spq_pkg::STATUS_FULL;
              end else begin
                ctl.op   = spq_pkg::CELL_INSERT;
                occ_next = occ + OCC_W'(1);
              end
            end
            spq_pkg::CMD_REMOVE: begin
              if (empty) begin
                done_next   = 1'b1;
                status_next = spq_pkg::STATUS_EMPTY;
              end else begin
                ctl.op        = spq_pkg::CELL_MATCH;
                cnt_next      = '0;
                key_hold_next = key;
              end
            end
            spq_pkg::CMD_POP: begin
              done_next = 1'b1;
              if (empty) begin
                status_next = spq_pkg::STATUS_EMPTY;
              end else begin
                ctl.op           = spq_pkg::CELL_SHIFT;
                ctl.shift_all    = 1'b1;
                removed_key_next = links[0].key;
                occ_next         = occ - OCC_W'(1);
              end
            end
            default: begin
              done_next   = 1'b1;
              status_next = empty ? spq_pkg::STATUS_EMPTY : spq_pkg::STATUS_DONE;
              occ_next    = '0;
            end
          endcase
        end
      end
      spq_pkg::ST_SCAN: begin
        if (scan_last) begin
          ctl.op           = spq_pkg::CELL_SHIFT;
          ctl.shift_all    = !found;
          done_next        = 1'b1;
          removed_key_next = found ? key_hold : links[0].key;
          fallback_next    = !found;
          occ_next         = occ - OCC_W'(1);
        end else begin
          ctl.op   = spq_pkg::CELL_SCAN;
          cnt_next = cnt + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::ST_IDLE;
      occ   <= '0;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    key_hold    <= key_hold_next;
    status      <= status_next;
    removed_key <= removed_key_next;
    fallback    <= fallback_next;
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(DEPTH))
    else $error("occupancy above depth");

  a_no_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result while scanning");

  a_fallback_done: assert property (@(posedge clk) disable iff (rst)
    (done && fallback) |-> (status == spq_pkg::STATUS_DONE))
    else $error("fallback with bad status");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    (accept && (command == spq_pkg::CMD_PUSH) && full)
      |=> (done && (status == spq_pkg::STATUS_FULL) && full))
    else $error("push into full queue not refused");

endmodule
